@@ rtl/task_slot_allocator_unit_assert.svh @@
// assertion macros used by the checker file tsa_chk.sv
`ifndef TASK_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define TASK_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define TSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsa assertion failed");

// antecedent holds, consequent in the next cycle
`define TSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsa assertion failed");

`endif

@@ rtl/tsa_pkg.sv @@
package tsa_pkg;

  localparam int PRIO_W      = 5;
  localparam int SLOT_FIELD_W = 5;
  localparam int GRANT_W     = 4;
  localparam int STATUS_W    = 3;
  localparam int PRIO_LEVELS = 32;

  typedef enum logic {
    CMD_CREATE = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_PRIO_SYS = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NO_SLOT  = 3'd3,
    ST_SYS_SLOT = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic                    cmd;
    logic [PRIO_W-1:0]       priority_req;
    logic [SLOT_FIELD_W-1:0] slot_id;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_slot;
  } out_word_t;

  typedef struct packed {
    logic cap;
    logic exe;
  } ctrl_cmd_t;

endpackage

@@ rtl/task_slot_allocator_unit.sv @@
// channel  dir  handshake              word
// in       in   in_valid_i/in_stall_o  in_word_i   (cmd, priority_req, slot_id)
// out      out  out_valid_o/out_stall_i out_word_o (status, granted_slot)
//
// each word is handled as capture with link and priority memory reads, then execute
// execute waits while the output register holds a stalled word
// in_stall_o is high during execute, so one word is in flight at a time
// reset: all slots free, chained in index order, priority table empty
module task_slot_allocator_unit #(
  parameter int SLOT_COUNT      = 16,
  parameter int LOWEST_PRIORITY = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsa_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsa_pkg::out_word_t out_word_o
);
  import tsa_pkg::*;

  ctrl_cmd_t cmd;

  tsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tsa_dp #(
    .SLOT_COUNT      (SLOT_COUNT),
    .LOWEST_PRIORITY (LOWEST_PRIORITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

@@ rtl/tsa_ctrl.sv @@
module tsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsa_pkg::ctrl_cmd_t cmd_o
);
  import tsa_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   can_load;

  assign can_load = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.cap  = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exe = can_load;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.exe) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ rtl/tsa_dp.sv @@
module tsa_dp #(
  parameter int SLOT_COUNT      = 16,
  parameter int LOWEST_PRIORITY = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsa_pkg::ctrl_cmd_t cmd_i,
  input  tsa_pkg::in_word_t  in_word_i,
  output tsa_pkg::out_word_t out_word_o
);
  import tsa_pkg::*;

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int HW    = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W = ((SW > SLOT_FIELD_W) ? SW : SLOT_FIELD_W) + 1;
  localparam logic [7:0] LowPrio = 8'(LOWEST_PRIORITY);
  localparam bit LowInTable = (LOWEST_PRIORITY < PRIO_LEVELS);
  localparam logic [PRIO_W-1:0] LowIdx = PRIO_W'(LOWEST_PRIORITY % PRIO_LEVELS);

  logic [HW-1:0]     link_mem [SLOT_COUNT];
  logic [PRIO_W-1:0] prio_mem [SLOT_COUNT];

  logic [HW-1:0]          head_q, head_d;
  logic [SLOT_COUNT-1:0]  used_q, link_vld_q;
  logic [PRIO_LEVELS-1:0] owned_q;

  logic              cmd_q;
  logic [PRIO_W-1:0] prio_q;
  logic [CMP_W-1:0]  sid_q;
  logic [HW-1:0]     link_rd_q;
  logic [PRIO_W-1:0] prio_rd_q;
  out_word_t         out_q;

  logic [CMP_W-1:0]    sid_in;
  logic [SW-1:0]       head_idx, sid_idx, sid_in_idx;
  logic                sid_ok, used_hit, owned_low, prio_ge, prio_is_sys;
  logic                do_take, do_free;
  logic [STATUS_W-1:0] status_d;
  logic [GRANT_W-1:0]  granted_d;

  assign sid_in     = CMP_W'(in_word_i.slot_id);
  assign sid_in_idx = sid_in[SW-1:0];
  assign head_idx   = head_q[SW-1:0];
  assign sid_idx    = sid_q[SW-1:0];

  assign sid_ok      = sid_q < CMP_W'(SLOT_COUNT);
  assign used_hit    = sid_ok && used_q[sid_idx];
  assign owned_low   = LowInTable && owned_q[LowIdx];
  assign prio_ge     = 8'(prio_q) >= LowPrio;
  assign prio_is_sys = 8'(prio_rd_q) == LowPrio;

  always_comb begin
    status_d  = ST_OK;
    granted_d = '0;
    do_take   = 1'b0;
    do_free   = 1'b0;
    if (cmd_q == CMD_CREATE) begin
      if (prio_ge && owned_low) begin
        status_d = ST_PRIO_SYS;
      end else if (head_q == HW'(SLOT_COUNT)) begin
        status_d = ST_EMPTY;
      end else begin
        do_take   = 1'b1;
        granted_d = GRANT_W'(head_q);
      end
    end else begin
      if (!used_hit) begin
        status_d = ST_NO_SLOT;
      end else if (prio_is_sys) begin
        status_d = ST_SYS_SLOT;
      end else begin
        do_free = 1'b1;
      end
    end
  end

  always_comb begin
    head_d = head_q;
    if (do_take) begin
      head_d = link_vld_q[head_idx] ? link_rd_q : head_q + HW'(1);
    end else if (do_free) begin
      head_d = HW'(sid_q);
    end
  end

  // link and priority memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.exe && do_free) begin
      link_mem[sid_idx] <= head_q;
    end
    if (cmd_i.cap) begin
      link_rd_q <= link_mem[head_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exe && do_take) begin
      prio_mem[head_idx] <= prio_q;
    end
    if (cmd_i.cap) begin
      prio_rd_q <= prio_mem[sid_in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cmd_q  <= in_word_i.cmd;
      prio_q <= in_word_i.priority_req;
      sid_q  <= sid_in;
    end
    if (cmd_i.exe) begin
      out_q.status       <= status_d;
      out_q.granted_slot <= granted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      used_q     <= '0;
      link_vld_q <= '0;
      owned_q    <= '0;
    end else if (cmd_i.exe) begin
      head_q <= head_d;
      if (do_take) begin
        used_q[head_idx] <= 1'b1;
        owned_q[prio_q]  <= 1'b1;
      end
      if (do_free) begin
        used_q[sid_idx]     <= 1'b0;
        link_vld_q[sid_idx] <= 1'b1;
        owned_q[prio_rd_q]  <= 1'b0;
      end
    end
  end

  assign out_word_o = out_q;

endmodule

@@ rtl/tsa_chk.sv @@
`include "task_slot_allocator_unit_assert.svh"

module tsa_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tsa_pkg::out_word_t out_word_o
);
  import tsa_pkg::*;

  `TSA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `TSA_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word_o))
  `TSA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `TSA_ASSERT_NOW(a_grant_only_ok, out_valid_o && (out_word_o.status != ST_OK),
                  out_word_o.granted_slot == '0)

endmodule

bind task_slot_allocator_unit tsa_chk u_chk (.*);
